// File: rtl/cgl_pkg.sv
// Package with the types, codes and preset table of the color gradient lookup.
`default_nettype none
package cgl_pkg;

	localparam int MaxStops = 16;
	localparam int IdxW = $clog2(MaxStops);
	localparam int CntW = $clog2(MaxStops + 1);

	typedef enum logic [2:0] {
		CMD_LOOKUP = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_CLEAR  = 3'd2,
		CMD_JET    = 3'd3,
		CMD_HOT    = 3'd4,
		CMD_GRAY   = 3'd5
	} cmd_code_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [15:0] value;
		logic [11:0]        stop_red;
		logic [11:0]        stop_green;
		logic [11:0]        stop_blue;
	} cmd_beat_t;

	typedef struct packed {
		logic [11:0] out_red;
		logic [11:0] out_green;
		logic [11:0] out_blue;
		logic [1:0]  status;
	} res_beat_t;

	typedef struct packed {
		logic signed [15:0] pos;
		logic [11:0]        r;
		logic [11:0]        g;
		logic [11:0]        b;
	} stop_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic            load;      // capture the command beat
		logic            rd;        // read entry rd_idx into the read register
		logic [IdxW-1:0] rd_idx;
		logic            cap_cur;   // move read data into the current stop
		logic            cap_prev;  // move current stop into the previous stop
		logic            wr;        // write a stop
		logic [IdxW-1:0] wr_idx;
		logic            wr_new;    // write the input stop, else the read data
		logic            wr_pre;    // write a preset stop
		logic [3:0]      pre_idx;
		logic            div_start;
		logic            blend;     // register the blended colors
		logic            take;      // register the colors of the stop just read
	} dp_cmd_t;

	// Datapath status to the controller.
	typedef struct packed {
		logic      less;      // value < position of the stop just read
		logic      div_done;
	} dp_stat_t;

	// Preset stops, jet then hot then grayscale, back to back.
	function automatic stop_t preset_stop(input logic [3:0] k);
		stop_t s;
		unique case (k)
			4'd0:  s = '{16'sd0,     12'd0,    12'd0,    12'd4095};
			4'd1:  s = '{16'sd4096,  12'd0,    12'd4095, 12'd4095};
			4'd2:  s = '{16'sd8192,  12'd0,    12'd4095, 12'd0};
			4'd3:  s = '{16'sd12288, 12'd4095, 12'd4095, 12'd0};
			4'd4:  s = '{16'sd16384, 12'd4095, 12'd0,    12'd0};
			4'd5:  s = '{16'sd0,     12'd0,    12'd0,    12'd0};
			4'd6:  s = '{16'sd2048,  12'd4095, 12'd0,    12'd0};
			4'd7:  s = '{16'sd9011,  12'd4095, 12'd4095, 12'd0};
			4'd8:  s = '{16'sd16384, 12'd4095, 12'd4095, 12'd4095};
			4'd9:  s = '{16'sd0,     12'd0,    12'd0,    12'd0};
			4'd10: s = '{16'sd16384, 12'd4095, 12'd4095, 12'd4095};
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// File: rtl/cgl_div.sv
// Restoring divider producing the Q1.15 blend fraction.
`default_nettype none
module cgl_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [16:0] num,
	input  wire logic [16:0] den,
	output logic             done,
	output logic [15:0]      frac
);
	// num never exceeds den when used, so the quotient is at most 32768 (1.0).
	logic [17:0] rem_q;
	logic [15:0] quo_q;
	logic [16:0] den_q;
	logic [3:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [17:0] trial;

	assign trial = {rem_q[16:0], 1'b0} - {1'b0, den_q};

	// One quotient bit per cycle, for bits 14..0 after the integer bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 4'd14;
			end else if (run_q) begin
				if (cnt_q == 4'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			if (num >= den) begin
				quo_q <= 16'd1;
				rem_q <= {1'b0, num - den};
			end else begin
				quo_q <= 16'd0;
				rem_q <= {1'b0, num};
			end
		end else if (run_q) begin
			if (!trial[17]) begin
				rem_q <= trial;
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[16:0], 1'b0};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	// Integer bit lands in bit 15, so 1.0 reads as 32768.
	assign frac = quo_q;
endmodule
`default_nettype wire

// File: rtl/cgl_datapath.sv
// Datapath: stop memory, current and previous stop, divider and blend.
`default_nettype none
module cgl_datapath (
	input  wire logic              clk,
	input  wire cgl_pkg::cmd_beat_t in_beat,
	input  wire cgl_pkg::dp_cmd_t  cmd,
	output cgl_pkg::dp_stat_t      stat,
	output cgl_pkg::cmd_beat_t     beat_q,
	output logic [11:0]            r_q,
	output logic [11:0]            g_q,
	output logic [11:0]            b_q,
	input  wire logic              arst_n
);
	cgl_pkg::stop_t mem [cgl_pkg::MaxStops];
	cgl_pkg::stop_t rd_q, cur_q, prev_q, wdat;
	logic [16:0] num, den;
	logic [15:0] frac;
	logic        div_done;

	// Captured command beat.
	always_ff @(posedge clk) begin
		if (cmd.load) beat_q <= in_beat;
	end

	// Stop memory, one write and one registered read port.
	always_comb begin
		if (cmd.wr_pre) wdat = cgl_pkg::preset_stop(cmd.pre_idx);
		else if (cmd.wr_new)
			wdat = '{beat_q.value, beat_q.stop_red, beat_q.stop_green, beat_q.stop_blue};
		else wdat = rd_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) mem[cmd.wr_idx] <= wdat;
		if (cmd.rd) rd_q <= mem[cmd.rd_idx];
	end

	// Current and previous stop of the scan.
	always_ff @(posedge clk) begin
		if (cmd.cap_prev) prev_q <= cur_q;
		if (cmd.cap_cur)  cur_q <= rd_q;
	end

	assign stat.less = beat_q.value < rd_q.pos;

	assign num = 17'(signed'({cur_q.pos[15], cur_q.pos})
		- signed'({beat_q.value[15], beat_q.value}));
	assign den = 17'(signed'({cur_q.pos[15], cur_q.pos})
		- signed'({prev_q.pos[15], prev_q.pos}));

	cgl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(num), .den(den), .done(div_done), .frac(frac)
	);
	assign stat.div_done = div_done;

	function automatic logic [11:0] mix(input logic [11:0] p, input logic [11:0] c,
		input logic [15:0] f);
		logic [11:0] d;
		logic [27:0] m;
		logic [11:0] t;
		d = (p >= c) ? p - c : c - p;
		m = d * f;
		t = m[26:15];
		return (p >= c) ? c + t : c - t;
	endfunction

	// Blend registers, one 12x16 product per channel; a single stop is taken as read.
	always_ff @(posedge clk) begin
		if (cmd.blend) begin
			r_q <= mix(prev_q.r, cur_q.r, frac);
			g_q <= mix(prev_q.g, cur_q.g, frac);
			b_q <= mix(prev_q.b, cur_q.b, frac);
		end else if (cmd.take) begin
			r_q <= rd_q.r;
			g_q <= rd_q.g;
			b_q <= rd_q.b;
		end
	end
endmodule
`default_nettype wire

// File: rtl/cgl_ctrl.sv
// Controller state machine sequencing the commands over the datapath.
`default_nettype none
module cgl_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire cgl_pkg::dp_stat_t    stat,
	input  wire logic [2:0]           bcmd,
	output cgl_pkg::dp_cmd_t          cmd,
	output logic                      busy,
	output logic                      done,
	output logic [1:0]                status,
	output logic                      use_blend,
	output logic                      use_cur
);
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DEC   = 8'b0000_0010,
		S_SCAN  = 8'b0000_0100,
		S_CHK   = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_SHIFT = 8'b0010_0000,
		S_PRE   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [cgl_pkg::CntW-1:0] count_q, idx_q, at_q;
	logic [3:0] pre_q, pre_end_q;
	logic [1:0] st_q;
	logic       blend_q, cur_q;
	logic       wr_pend_q, div_go_q;
	logic [cgl_pkg::CntW-1:0] pre_n;
	logic       last_idx;

	always_comb begin
		case (bcmd)
			cgl_pkg::CMD_JET: pre_n = cgl_pkg::CntW'(5);
			cgl_pkg::CMD_HOT: pre_n = cgl_pkg::CntW'(4);
			default:          pre_n = cgl_pkg::CntW'(2);
		endcase
	end

	assign last_idx = (idx_q == count_q - cgl_pkg::CntW'(1));
	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign status = st_q;
	assign use_blend = blend_q;
	assign use_cur = cur_q;

	// Command outputs.
	always_comb begin
		cmd = '0;
		cmd.load = start && state_q == S_IDLE;
		cmd.rd_idx = idx_q[cgl_pkg::IdxW-1:0];
		cmd.wr_idx = idx_q[cgl_pkg::IdxW-1:0];
		cmd.pre_idx = pre_q;
		cmd.div_start = div_go_q;
		unique case (state_q)
			S_SCAN: cmd.rd = 1'b1;
			S_CHK: begin
				cmd.cap_cur = 1'b1;
				cmd.cap_prev = 1'b1;
				// A lookup ending on one stop takes that stop's colors as read.
				if (bcmd == cgl_pkg::CMD_LOOKUP && (stat.less ? idx_q == '0 : last_idx))
					cmd.take = 1'b1;
			end
			S_DIV: cmd.blend = stat.div_done;
			S_SHIFT: begin
				// Shift down from the top, then place the new stop.
				if (idx_q == at_q) begin
					cmd.wr = 1'b1;
					cmd.wr_new = 1'b1;
				end else if (wr_pend_q) begin
					cmd.wr = 1'b1;
				end else begin
					cmd.rd = 1'b1;
					cmd.rd_idx = cgl_pkg::IdxW'(idx_q - cgl_pkg::CntW'(1));
				end
			end
			S_PRE: begin
				cmd.wr = 1'b1;
				cmd.wr_pre = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			at_q <= '0;
			pre_q <= '0;
			pre_end_q <= '0;
			st_q <= cgl_pkg::ST_OK;
			blend_q <= 1'b0;
			cur_q <= 1'b0;
			wr_pend_q <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_DEC;
				S_DEC: begin
					blend_q <= 1'b0;
					cur_q <= 1'b0;
					wr_pend_q <= 1'b0;
					case (bcmd) inside
						cgl_pkg::CMD_LOOKUP: begin
							idx_q <= '0;
							if (count_q == '0) begin
								st_q <= cgl_pkg::ST_EMPTY;
								state_q <= S_DONE;
							end else begin
								st_q <= cgl_pkg::ST_OK;
								state_q <= S_SCAN;
							end
						end
						cgl_pkg::CMD_INSERT: begin
							idx_q <= '0;
							if (count_q == cgl_pkg::CntW'(cgl_pkg::MaxStops)) begin
								st_q <= cgl_pkg::ST_FULL;
								state_q <= S_DONE;
							end else begin
								st_q <= cgl_pkg::ST_OK;
								at_q <= count_q;
								state_q <= (count_q == '0) ? S_SHIFT : S_SCAN;
							end
						end
						cgl_pkg::CMD_CLEAR: begin
							st_q <= cgl_pkg::ST_OK;
							count_q <= '0;
							state_q <= S_DONE;
						end
						cgl_pkg::CMD_JET, cgl_pkg::CMD_HOT, cgl_pkg::CMD_GRAY: begin
							if ((cgl_pkg::CntW+1)'(count_q) + (cgl_pkg::CntW+1)'(pre_n) >
								(cgl_pkg::CntW+1)'(cgl_pkg::MaxStops)) begin
								st_q <= cgl_pkg::ST_FULL;
								state_q <= S_DONE;
							end else begin
								st_q <= cgl_pkg::ST_OK;
								idx_q <= count_q;
								pre_q <= (bcmd == cgl_pkg::CMD_JET) ? 4'd0 :
									(bcmd == cgl_pkg::CMD_HOT) ? 4'd5 : 4'd9;
								pre_end_q <= (bcmd == cgl_pkg::CMD_JET) ? 4'd4 :
									(bcmd == cgl_pkg::CMD_HOT) ? 4'd8 : 4'd10;
								state_q <= S_PRE;
							end
						end
						default: begin
							st_q <= cgl_pkg::ST_OK;
							state_q <= S_DONE;
						end
					endcase
				end
				S_SCAN: state_q <= S_CHK;
				S_CHK: begin
					if (bcmd == cgl_pkg::CMD_LOOKUP) begin
						if (stat.less) begin
							if (idx_q == '0) begin
								cur_q <= 1'b1;
								state_q <= S_DONE;
							end else begin
								blend_q <= 1'b1;
								div_go_q <= 1'b1;
								state_q <= S_DIV;
							end
						end else if (last_idx) begin
							cur_q <= 1'b1;
							state_q <= S_DONE;
						end else begin
							idx_q <= idx_q + cgl_pkg::CntW'(1);
							state_q <= S_SCAN;
						end
					end else begin
						// Insert: first greater stop, or the end.
						if (stat.less) begin
							at_q <= idx_q;
							idx_q <= count_q;
							state_q <= S_SHIFT;
						end else if (last_idx) begin
							at_q <= count_q;
							idx_q <= count_q;
							state_q <= S_SHIFT;
						end else begin
							idx_q <= idx_q + cgl_pkg::CntW'(1);
							state_q <= S_SCAN;
						end
					end
				end
				S_DIV: begin
					// The divider starts on entry to this state, once both stops are captured.
					div_go_q <= 1'b0;
					if (stat.div_done) state_q <= S_DONE;
				end
				S_SHIFT: begin
					// Read entry idx-1 into the read register, then write it to idx.
					if (idx_q == at_q) begin
						count_q <= count_q + cgl_pkg::CntW'(1);
						state_q <= S_DONE;
					end else if (wr_pend_q) begin
						wr_pend_q <= 1'b0;
						idx_q <= idx_q - cgl_pkg::CntW'(1);
					end else wr_pend_q <= 1'b1;
				end
				S_PRE: begin
					idx_q <= idx_q + cgl_pkg::CntW'(1);
					count_q <= count_q + cgl_pkg::CntW'(1);
					pre_q <= pre_q + 4'd1;
					if (pre_q == pre_end_q) state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/color_gradient_lookup.sv
// Top level of the color gradient lookup: controller, datapath and result beat.
// From the accepting edge to the result strobe: clear, unused codes, empty or full go straight to the strobe;
// presets write their stops in turn; insert scans for its place unless the table is empty, then shifts up;
// lookup scans the stops and, when two stops are blended, also waits for the divider.
// Busy stays high through the strobe cycle, so the next beat is taken in the cycle after;
// the strobe cannot be stalled. Reset clears the stop count, not the stop memory.
`default_nettype none
module color_gradient_lookup (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire cgl_pkg::cmd_beat_t cmd_in,
	output logic                    done,
	output cgl_pkg::res_beat_t      result
);
	cgl_pkg::dp_cmd_t   dcmd;
	cgl_pkg::dp_stat_t  dstat;
	cgl_pkg::cmd_beat_t beat_q;
	logic [11:0] r_q, g_q, b_q;
	logic [1:0]  st;
	logic        use_blend, use_cur;
	logic        fin;

	cgl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.stat(dstat), .bcmd(beat_q.command), .cmd(dcmd), .busy(busy), .done(fin),
		.status(st), .use_blend(use_blend), .use_cur(use_cur)
	);

	cgl_datapath u_dp (
		.clk(clk), .in_beat(cmd_in), .cmd(dcmd), .stat(dstat), .beat_q(beat_q),
		.r_q(r_q), .g_q(g_q), .b_q(b_q), .arst_n(arst_n)
	);

	// Result beat: colors only for a lookup that found stops.
	assign done = fin;
	always_comb begin
		result = '0;
		result.status = st;
		if (use_blend || use_cur) begin
			result.out_red = r_q;
			result.out_green = g_q;
			result.out_blue = b_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result strobe outside a command");
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("command not taken");
endmodule
`default_nettype wire
